@@ rtl/qcmp_pkg.sv @@
// shared types, codes and constants for the qr codeword module placer
// no dependencies; rtl (bar qcmp_ram) uses scoped names, test files import it
package qcmp_pkg;

  localparam int unsigned MaxSideDef = 177;  // largest symbol side supported
  localparam int unsigned MinSide    = 21;   // smallest legal symbol side
  localparam int unsigned TimingCol  = 6;    // vertical timing pattern column
  localparam int unsigned SideW      = 8;
  localparam int unsigned WordW      = 12;
  localparam int unsigned SideRst    = 21;
  localparam int unsigned WordRst    = 26;
  localparam int unsigned DataRst    = 26;

  typedef enum logic [1:0] {
    FN_MARK  = 2'd0,
    FN_PLACE = 2'd1,
    FN_START = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_START_OK = 2'd1,
    ST_SIZE_ERR = 2'd2,
    ST_REJECT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_PLACE = 2'd1,
    OP_START = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_SIDE  = 2'd0,
    CFG_WORDS = 2'd1,
    CFG_DATA  = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] mark_col;
    logic [7:0] mark_row;
    logic       mark_bit;
    logic [7:0] codeword;
  } in_item_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       bit_res;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e        op;
    logic [7:0] mark_col;
    logic [7:0] mark_row;
    logic       mark_bit;
    logic [7:0] codeword;
  } cmd_t;

  // zigzag walk position
  typedef struct packed {
    logic signed [8:0] col;
    logic [7:0]        row;
    logic              step_right;
    logic              going_down;
  } walk_t;

  // one raw step of the two-column zigzag; no mask or column bounds checks
  function automatic walk_t walk_step(walk_t w, logic [7:0] side);
    walk_t             n;
    logic signed [9:0] r;
    logic signed [9:0] sd;
    n  = w;
    sd = signed'({2'b00, side});
    r  = signed'({2'b00, w.row});
    n.col        = w.step_right ? (w.col + 9'sd1) : (w.col - 9'sd1);
    n.step_right = ~w.step_right;
    if (!n.step_right) begin
      r = w.going_down ? (r + 10'sd1) : (r - 10'sd1);
      if (r < 10'sd0 || r >= sd) begin
        n.row        = (r < 10'sd0) ? 8'd0 : (side - 8'd1);
        n.going_down = ~w.going_down;
        n.col        = n.col - 9'sd2;
        if (n.col == signed'(9'(TimingCol))) begin
          n.col = n.col - 9'sd1;
        end
      end else begin
        n.row = r[7:0];
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/qcmp_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module qcmp_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/qcmp_front.sv @@
// front end: accepts input words, classifies them and queues commands
// depends on qcmp_pkg
module qcmp_front #(
  parameter int unsigned MaxSide = qcmp_pkg::MaxSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qcmp_pkg::in_item_t  in_data_i,
  input  logic                hold_i,
  output logic                cmd_valid_o,
  output qcmp_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  localparam int unsigned QDepth = 2;

  qcmp_pkg::cmd_t fifo_q [QDepth];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  qcmp_pkg::cmd_t cmd_new;
  logic           keep;
  logic           push;

  // decode func; out of range marks are dropped here
  always_comb begin
    cmd_new.mark_col = in_data_i.mark_col;
    cmd_new.mark_row = in_data_i.mark_row;
    cmd_new.mark_bit = in_data_i.mark_bit;
    cmd_new.codeword = in_data_i.codeword;
    keep             = 1'b1;
    case (in_data_i.func)
      qcmp_pkg::FN_MARK: begin
        cmd_new.op = qcmp_pkg::OP_MARK;
        keep = (32'(in_data_i.mark_col) < MaxSide) && (32'(in_data_i.mark_row) < MaxSide);
      end
      qcmp_pkg::FN_PLACE: begin
        cmd_new.op = qcmp_pkg::OP_PLACE;
      end
      qcmp_pkg::FN_START: begin
        cmd_new.op = qcmp_pkg::OP_START;
      end
      default: begin
        cmd_new.op = qcmp_pkg::OP_BAD;
      end
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'(QDepth)) || hold_i;
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/qcmp_back.sv @@
// back end: clears and writes the function mask, runs the zigzag walk, drives results
// depends on qcmp_pkg and qcmp_ram
module qcmp_back #(
  parameter int unsigned MaxSide = qcmp_pkg::MaxSideDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [qcmp_pkg::SideW-1:0]      side_i,
  input  logic [qcmp_pkg::WordW-1:0]      word_total_i,
  input  logic [qcmp_pkg::WordW-1:0]      data_total_i,
  input  logic                            cmd_valid_i,
  input  qcmp_pkg::cmd_t                  cmd_i,
  output logic                            cmd_pop_o,
  output logic                            clearing_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output qcmp_pkg::out_item_t             out_data_o
);

  localparam int unsigned Depth = MaxSide * MaxSide;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 clr_q, clr_d;
  qcmp_pkg::walk_t               walk_q, walk_d;
  qcmp_pkg::walk_t               cand_q, cand_d;
  logic                          cand_valid_q, cand_valid_d;
  logic                          cand_oor_q, cand_oor_d;
  logic                          cand_skip_q, cand_skip_d;
  logic                          stop_q, stop_d;
  logic [2:0]                    bit_idx_q, bit_idx_d;
  logic [7:0]                    cw_q, cw_d;
  logic [qcmp_pkg::WordW-1:0]    words_q, words_d;
  logic                          armed_q, armed_d;
  logic                          out_valid_q, out_valid_d;
  qcmp_pkg::out_item_t           out_q, out_d;

  qcmp_pkg::walk_t               nxt;
  logic                          nxt_oor, nxt_skip;
  logic signed [8:0]             side_s;
  logic                          side_ok;
  logic                          out_free;
  logic                          need_emit, chk_go, finishing, issue;
  logic                          ram_we, ram_wdata, ram_re, ram_rdata;
  logic [AW-1:0]                 ram_waddr, ram_raddr, mark_addr;

  assign side_s   = signed'({1'b0, side_i});
  assign side_ok  = (side_i >= 8'(qcmp_pkg::MinSide)) && (32'(side_i) <= MaxSide);
  assign out_free = !out_valid_q || !out_stall_i;

  // next candidate module of the walk and its mask address
  assign nxt       = qcmp_pkg::walk_step(walk_q, side_i);
  assign nxt_oor   = (nxt.col < 9'sd0);
  assign nxt_skip  = !nxt_oor && ((nxt.col >= side_s) || (nxt.row >= side_i));
  assign ram_raddr = AW'(32'(nxt.col[7:0]) * MaxSide + 32'(nxt.row));
  assign mark_addr = AW'(32'(cmd_i.mark_col) * MaxSide + 32'(cmd_i.mark_row));

  // check stage: candidate's mask bit, read at issue, is held in ram_rdata
  assign need_emit = cand_valid_q && (cand_oor_q || (!cand_skip_q && !ram_rdata));
  assign chk_go    = !need_emit || out_free;
  assign finishing = cand_valid_q && chk_go &&
                     (cand_oor_q || (!cand_skip_q && !ram_rdata && (bit_idx_q == 3'd7)));
  assign issue     = (state_q == S_RUN) && chk_go && !stop_q && !finishing;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    walk_d       = walk_q;
    cand_d       = cand_q;
    cand_valid_d = cand_valid_q;
    cand_oor_d   = cand_oor_q;
    cand_skip_d  = cand_skip_q;
    stop_d       = stop_q;
    bit_idx_d    = bit_idx_q;
    cw_d         = cw_q;
    words_d      = words_q;
    armed_d      = armed_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = mark_addr;
    ram_wdata    = cmd_i.mark_bit;
    ram_re       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            qcmp_pkg::OP_MARK: begin
              ram_we = 1'b1;
            end
            qcmp_pkg::OP_START: begin
              out_valid_d = 1'b1;
              out_d       = '0;
              out_d.last  = 1'b1;
              if (data_total_i > word_total_i) begin
                armed_d      = 1'b0;
                out_d.status = qcmp_pkg::ST_SIZE_ERR;
              end else if (!side_ok) begin
                armed_d      = 1'b0;
                out_d.status = qcmp_pkg::ST_REJECT;
              end else begin
                walk_d.col        = signed'({1'b0, side_i});
                walk_d.row        = side_i - 8'd1;
                walk_d.step_right = 1'b1;
                walk_d.going_down = 1'b1;
                words_d           = '0;
                armed_d           = 1'b1;
                out_d.status      = qcmp_pkg::ST_START_OK;
              end
            end
            qcmp_pkg::OP_PLACE: begin
              if (!armed_q || (words_q >= word_total_i) || !side_ok) begin
                out_valid_d  = 1'b1;
                out_d        = '0;
                out_d.status = qcmp_pkg::ST_REJECT;
                out_d.last   = 1'b1;
              end else begin
                state_d      = S_RUN;
                cw_d         = cmd_i.codeword;
                bit_idx_d    = 3'd0;
                stop_d       = 1'b0;
                cand_valid_d = 1'b0;
              end
            end
            default: begin
              out_valid_d  = 1'b1;
              out_d        = '0;
              out_d.status = qcmp_pkg::ST_REJECT;
              out_d.last   = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        // issue stage runs one candidate ahead of the check stage
        if (issue) begin
          ram_re       = 1'b1;
          walk_d       = nxt;
          cand_d       = nxt;
          cand_valid_d = 1'b1;
          cand_oor_d   = nxt_oor;
          cand_skip_d  = nxt_skip;
          stop_d       = nxt_oor;
        end else if (chk_go) begin
          cand_valid_d = 1'b0;
        end
        if (need_emit && chk_go) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (cand_oor_q) begin
            out_d.status = qcmp_pkg::ST_REJECT;
            out_d.last   = 1'b1;
            armed_d      = 1'b0;
            cand_valid_d = 1'b0;
            state_d      = S_IDLE;
          end else begin
            out_d.col     = cand_q.col[7:0];
            out_d.row     = cand_q.row;
            out_d.bit_res = cw_q[3'd7 - bit_idx_q];
            out_d.status  = qcmp_pkg::ST_PLACED;
            out_d.last    = (bit_idx_q == 3'd7);
            bit_idx_d     = bit_idx_q + 3'd1;
            if (bit_idx_q == 3'd7) begin
              // drop the lookahead candidate, walk resumes from the last placement
              words_d      = words_q + 12'd1;
              walk_d       = cand_q;
              cand_valid_d = 1'b0;
              state_d      = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      clr_q             <= '0;
      walk_q.col        <= 9'(qcmp_pkg::SideRst);
      walk_q.row        <= 8'(qcmp_pkg::SideRst - 1);
      walk_q.step_right <= 1'b1;
      walk_q.going_down <= 1'b1;
      cand_q            <= '0;
      cand_valid_q      <= 1'b0;
      cand_oor_q        <= 1'b0;
      cand_skip_q       <= 1'b0;
      stop_q            <= 1'b0;
      bit_idx_q         <= 3'd0;
      cw_q              <= 8'd0;
      words_q           <= '0;
      armed_q           <= 1'b0;
      out_valid_q       <= 1'b0;
      out_q             <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      walk_q       <= walk_d;
      cand_q       <= cand_d;
      cand_valid_q <= cand_valid_d;
      cand_oor_q   <= cand_oor_d;
      cand_skip_q  <= cand_skip_d;
      stop_q       <= stop_d;
      bit_idx_q    <= bit_idx_d;
      cw_q         <= cw_d;
      words_q      <= words_d;
      armed_q      <= armed_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  qcmp_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_mask (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cand_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_valid_q |-> (state_q == S_RUN))
    else $error("candidate pending outside the walk");

  a_no_pop_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !cmd_pop_o)
    else $error("command taken during mask clear");

  a_no_issue_after_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> !ram_re)
    else $error("walk continued past the left edge");

  a_placed_in_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == qcmp_pkg::ST_PLACED)) |->
      ((32'(out_q.col) < MaxSide) && (32'(out_q.row) < MaxSide)))
    else $error("placement outside the symbol");

endmodule

@@ rtl/qr_codeword_module_placer_unit.sv @@
// top level of the qr codeword module placer: config registers, front and back
// depends on qcmp_pkg, qcmp_front, qcmp_back (and qcmp_ram below it)
//
// usage
// - input channel (in_valid_i / in_stall_o / in_data_i) carries one word per item:
//   func 0 writes a function mark, 1 places a codeword, 2 starts a symbol
// - output channel (out_valid_o / out_stall_i / out_data_o) returns results;
//   last flags the final result of an item. a mark gives no result, a start or
//   rejected item gives one status word, a codeword gives eight placements
//   (or its placements so far plus one out-of-room status word)
// - config registers are written through cfg_valid_i / cfg_index_i / cfg_data_i
//   while the block is idle; cfg_ready_o is always high
// - a start or rejected item's status word is set straight into the output
//   register; a codeword's placements come from the walk, which also steps
//   through skipped modules (function mark or off-symbol), not the timing column
// - one mask ram read port bounds the walk: one candidate a cycle unless stalled
// - a two-entry command queue sits between front and back, so input words are
//   still taken while the back end walks or the output is stalled
// - after reset the mask ram is swept clear, all MaxSide*MaxSide entries (31329 at
//   the default); in_stall_o stays high during the sweep
// - when out_stall_i is high a valid output word holds and the walk waits to emit
module qr_codeword_module_placer_unit #(
  parameter int unsigned MaxSide = qcmp_pkg::MaxSideDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  qcmp_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output qcmp_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [qcmp_pkg::WordW-1:0]   cfg_data_i
);

  logic [qcmp_pkg::SideW-1:0] side_q;
  logic [qcmp_pkg::WordW-1:0] word_total_q;
  logic [qcmp_pkg::WordW-1:0] data_total_q;

  logic           cmd_valid;
  qcmp_pkg::cmd_t cmd;
  logic           cmd_pop;
  logic           clearing;

  // config writes are always taken; cfg_ready_o is tied high
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q       <= 8'(qcmp_pkg::SideRst);
      word_total_q <= 12'(qcmp_pkg::WordRst);
      data_total_q <= 12'(qcmp_pkg::DataRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qcmp_pkg::CFG_SIDE:  side_q       <= cfg_data_i[qcmp_pkg::SideW-1:0];
        qcmp_pkg::CFG_WORDS: word_total_q <= cfg_data_i;
        qcmp_pkg::CFG_DATA:  data_total_q <= cfg_data_i;
        default: begin
          // unknown index, write is dropped
        end
      endcase
    end
  end

  // front: decode and queue
  qcmp_front #(
    .MaxSide (MaxSide)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .hold_i      (clearing),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: mask ram, zigzag walk and output register
  qcmp_back #(
    .MaxSide (MaxSide)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .side_i       (side_q),
    .word_total_i (word_total_q),
    .data_total_i (data_total_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ test/placement_check_pkg.sv @@
`timescale 1ns / 100ps
// scoreboard for the qr codeword module placer bench: predicts placement and status words
// from accepted input words and checks results in order; depends on qcmp_pkg
package placement_check_pkg;
  import qcmp_pkg::*;

  class placement_scoreboard;
    logic [7:0]  side_q;
    logic [11:0] words_q;
    logic [11:0] data_q;
    bit          func_mask [MaxSideDef*MaxSideDef];
    int          walk_col;
    int          walk_row;
    bit          step_right;
    bit          going_down;
    logic [11:0] words_done;
    bit          armed;
    out_item_t   expected_placements [$];
    int          errors;

    function new();
      side_q = 8'(SideRst);
      words_q = 12'(WordRst);
      data_q = 12'(DataRst);
      foreach (func_mask[i]) func_mask[i] = 1'b0;
      words_done = '0;
      armed = 1'b0;
      errors = 0;
      rearm();
    endfunction

    function void write_reg(cfg_e idx, logic [11:0] value);
      case (idx)
        CFG_SIDE:  side_q = value[7:0];
        CFG_WORDS: words_q = value;
        CFG_DATA:  data_q = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_placements.size();
    endfunction

    function bit side_legal();
      return side_q >= MinSide && side_q <= MaxSideDef;
    endfunction

    function void rearm();
      walk_col = int'(side_q);
      walk_row = int'(side_q) - 1;
      step_right = 1'b1;
      going_down = 1'b1;
    endfunction

    function void expect_word(logic [7:0] c, logic [7:0] r, logic b, status_e st, logic lst);
      out_item_t w;
      w.col = c;
      w.row = r;
      w.bit_res = b;
      w.status = st;
      w.last = lst;
      expected_placements.push_back(w);
    endfunction

    // zigzag to the next free module, 0 once the walk falls off the left edge
    function bit next_free();
      int sd;
      sd = int'(side_q);
      while (1'b1) begin
        walk_col += step_right ? 1 : -1;
        step_right = !step_right;
        if (!step_right) begin
          walk_row += going_down ? 1 : -1;
          if (walk_row < 0 || walk_row >= sd) begin
            walk_row = (walk_row < 0) ? 0 : sd - 1;
            going_down = !going_down;
            walk_col -= 2;
            if (walk_col == TimingCol) walk_col -= 1;
          end
        end
        if (walk_col < 0) return 1'b0;
        if (walk_col < sd && walk_row < sd && !func_mask[walk_col * MaxSideDef + walk_row])
          return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_word(in_item_t it);
      int j;
      case (it.func)
        FN_MARK: begin
          if (it.mark_col < MaxSideDef && it.mark_row < MaxSideDef)
            func_mask[it.mark_col * MaxSideDef + it.mark_row] = it.mark_bit;
        end
        FN_START: begin
          if (data_q > words_q) begin
            armed = 1'b0;
            expect_word('0, '0, 1'b0, ST_SIZE_ERR, 1'b1);
          end else if (!side_legal()) begin
            armed = 1'b0;
            expect_word('0, '0, 1'b0, ST_REJECT, 1'b1);
          end else begin
            rearm();
            words_done = '0;
            armed = 1'b1;
            expect_word('0, '0, 1'b0, ST_START_OK, 1'b1);
          end
        end
        FN_PLACE: begin
          if (armed && words_done < words_q && side_legal()) begin
            for (j = 0; j < 8; j++) begin
              if (!next_free()) begin
                armed = 1'b0;
                expect_word('0, '0, 1'b0, ST_REJECT, 1'b1);
                return;
              end
              expect_word(8'(walk_col), 8'(walk_row), it.codeword[7-j], ST_PLACED, j == 7);
            end
            words_done = words_done + 12'd1;
          end else begin
            expect_word('0, '0, 1'b0, ST_REJECT, 1'b1);
          end
        end
        default: expect_word('0, '0, 1'b0, ST_REJECT, 1'b1);
      endcase
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (expected_placements.size() == 0) begin
        errors++;
        $error("unexpected word: col %0d row %0d bit_res %0d status %0d last %0d",
               got.col, got.row, got.bit_res, got.status, got.last);
        return;
      end
      want = expected_placements.pop_front();
      compare("col", want.col, got.col);
      compare("row", want.row, got.row);
      compare("bit_res", 8'(want.bit_res), 8'(got.bit_res));
      compare("status", 8'(want.status), 8'(got.status));
      compare("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

endpackage

@@ test/tb_qr_codeword_module_placer_unit.sv @@
`timescale 1ns / 100ps
// top of the qr codeword module placer bench: clock, reset, stimulus, idling and verdict
// depends on qcmp_pkg, placement_check_pkg and qr_codeword_module_placer_unit
module tb_qr_codeword_module_placer_unit;
  import qcmp_pkg::*;
  import placement_check_pkg::*;

  localparam int RandomItems = 410;
  localparam int CalmItems   = 60;      // tail of the run with no idling at all
  localparam int CycleLimit  = 1000000; // covers the mask sweep after reset many times over
  localparam int MarkDrain   = 20;      // marks give no result; let them leave the queue
  localparam int TailCycles  = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  placement_scoreboard board;
  int gap_pct;     // chance per word that the sender idles first
  int stall_pct;   // chance per cycle that the receiver starts a stall burst
  int items_sent;
  int cycles = 0;

  qr_codeword_module_placer_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop; a hang or a lost result ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb_qr_codeword_module_placer_unit: errors");
      $finish;
    end
  end

  // every field but func random; callers overwrite the ones that matter
  function automatic in_item_t rand_item(logic [1:0] fn);
    in_item_t it;
    it.func = fn;
    it.mark_col = 8'($urandom);
    it.mark_row = 8'($urandom);
    it.mark_bit = 1'($urandom);
    it.codeword = 8'($urandom);
    return it;
  endfunction

  // hold valid and the word until taken; valid stays up for a following word
  task automatic send(input in_item_t it);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(it);
    items_sent++;
  endtask

  task automatic mark_at(input int c, input int r, input bit b);
    in_item_t it;
    it = rand_item(FN_MARK);
    it.mark_col = 8'(c);
    it.mark_row = 8'(r);
    it.mark_bit = b;
    send(it);
  endtask

  task automatic place_byte(input logic [7:0] cw);
    in_item_t it;
    it = rand_item(FN_PLACE);
    it.codeword = cw;
    send(it);
  endtask

  task automatic start_symbol();
    send(rand_item(FN_START));
  endtask

  task automatic bad_func();
    send(rand_item(OP_BAD));
  endtask

  // sender holds off until every expected word is back and trailing marks are done
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (MarkDrain) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_e idx, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, value);
  endtask

  task automatic set_regs(input int side, input int words, input int data);
    put_reg(CFG_SIDE, 12'(side));
    put_reg(CFG_WORDS, 12'(words));
    put_reg(CFG_DATA, 12'(data));
    cfg_valid <= 1'b0;
  endtask

  // result side: check every accepted word, stall in random bursts
  initial begin : result_side
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_word(out_data);
      if (hold > 0) begin
        hold--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 13);
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin : stimulus
    int side;
    int eff;
    int words;
    int data;
    int len;
    int pick;
    int k;
    board = new();
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SIDE;
    cfg_data = '0;
    rst_n = 1'b0;
    gap_pct = 15;
    stall_pct = 10;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // nothing armed yet: a codeword and the unused function code are both refused
    place_byte(8'hFF);
    bad_func();
    // marks at the far corner, off the mask (ignored), on the walk, and set then cleared
    mark_at(176, 176, 1'b1);
    mark_at(177, 3, 1'b1);
    mark_at(3, 255, 1'b1);
    mark_at(20, 19, 1'b1);
    mark_at(19, 19, 1'b1);
    mark_at(19, 19, 1'b0);
    start_symbol();
    place_byte(8'hFF);
    place_byte(8'h00);
    place_byte(8'hA5);
    place_byte(8'h5A);

    // word quota of two with empty data: third codeword refused
    settle();
    set_regs(MinSide, 2, 0);
    start_symbol();
    place_byte(8'h80);
    place_byte(8'h01);
    place_byte(8'h3C);

    // data longer than the word count: size error, then disarmed
    settle();
    set_regs(MinSide, 1, 4095);
    start_symbol();
    place_byte(8'h77);

    // side just below legal
    settle();
    set_regs(MinSide - 1, 4095, 4095);
    start_symbol();

    // largest symbol, then an illegal side while armed, then back with junk upper bits
    settle();
    set_regs(MaxSideDef, 3706, 3706);
    start_symbol();
    place_byte(8'hC3);
    settle();
    set_regs(MaxSideDef + 1, 3706, 3706);
    place_byte(8'h3C);
    settle();
    set_regs(12'hF00 | MaxSideDef, 3706, 3706);
    place_byte(8'h96);
    // side shrinks under a walk near the right edge: everything off-symbol is skipped
    settle();
    set_regs(MinSide, 3706, 3706);
    place_byte(8'h69);

    // fill a small symbol until the walk runs out of columns
    settle();
    set_regs(MinSide, 4095, 0);
    start_symbol();
    repeat (56) place_byte(8'($urandom));

    while (items_sent < RandomItems) begin
      settle();
      if (items_sent >= RandomItems - CalmItems) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 15;
        endcase
      end

      pick = $urandom_range(0, 99);
      if (pick < 15) side = MinSide;
      else if (pick < 30) side = MaxSideDef;
      else if (pick < 38) side = $urandom_range(0, MinSide - 1);
      else if (pick < 44) side = $urandom_range(MaxSideDef + 1, 255);
      else side = $urandom_range(MinSide, MaxSideDef);
      eff = side;
      if ($urandom_range(0, 7) == 0) side = side + ($urandom_range(1, 15) << 8);
      words = ($urandom_range(0, 9) == 0) ? $urandom_range(3706, 4095) : $urandom_range(0, 40);
      if ($urandom_range(0, 5) == 0) data = words + $urandom_range(1, 40);
      else data = $urandom_range(0, words);
      if (data > 4095) data = 4095;
      set_regs(side, words, data);

      // marks near the corner where the walk begins
      repeat ($urandom_range(0, 6)) begin
        if (eff >= MinSide)
          mark_at(eff - 1 - $urandom_range(0, 7), eff - 1 - $urandom_range(0, 20),
                  1'($urandom));
        else
          mark_at($urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom));
      end
      // now and then no start, so the walk carries on under the new side
      if ($urandom_range(0, 5) != 0) start_symbol();

      len = $urandom_range(1, (words + 3 > 48) ? 48 : words + 3);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) place_byte(8'($urandom));
        else if (pick < 93) mark_at($urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom));
        else if (pick < 96) start_symbol();
        else bad_func();
      end
    end

    gap_pct = 0;
    stall_pct = 0;
    settle();
    repeat (TailCycles) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_qr_codeword_module_placer_unit: clean");
    end else begin
      $display("tb_qr_codeword_module_placer_unit: errors");
    end
    $finish;
  end

endmodule
